// ----- rtl/core/arft_pkg.sv -----
// Shared types and constants for the address range filter table.
// Item and result payload structs, item kind codes, default sizes.
// No dependencies.
package arft_pkg;

    localparam int MAX_RANGES_DEF  = 256;
    localparam int BATCH_LIMIT_DEF = 8;

    localparam int ADDR_W      = 64;
    localparam int OFFSET_W    = 32;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 9;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   range_base;
        logic [OFFSET_W-1:0] begin_offset;
        logic [OFFSET_W-1:0] end_offset;
        logic                last_in_batch;
    } arft_item_t;

    typedef struct packed {
        logic                   hit;
        logic                   stored;
        logic [COUNT_OUT_W-1:0] entry_count;
    } arft_result_t;

    // One stored half-open range [range_lo, range_hi).
    typedef struct packed {
        logic [ADDR_W-1:0] range_lo;
        logic [ADDR_W-1:0] range_hi;
    } arft_range_t;

endpackage

// ----- rtl/core/arft_range_store.sv -----
// Range storage for the address range filter table.
// One write port, one read port with registered read data.
// Depends on arft_pkg.
module arft_range_store
    import arft_pkg::*;
#(
    parameter int DEPTH = MAX_RANGES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  arft_range_t      wr_range,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output arft_range_t      rd_range
);

    arft_range_t mem [DEPTH];
    arft_range_t rd_range_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_range_reg <= mem[rd_idx];
        end
    end

    assign rd_range = rd_range_reg;

endmodule

// ----- rtl/core/address_range_filter_table_core.sv -----
// Top level of the address range filter table.
// Sequencer, batch and count tracking, range compare unit, result register.
// Depends on arft_pkg and arft_range_store.
//
// Usage:
//   Items enter on item/item_valid/item_stall, results leave on
//   result/result_valid/result_stall; a transaction completes at a rising
//   edge with valid high and stall low. Every item gives one result.
//   Clear, add and unused-kind items, and a lookup on an empty table,
//   finish in the accepting cycle; their result is valid in the next cycle.
//   A lookup on a non-empty table scans the stored ranges one per cycle
//   through a single memory read port and one shared two-sided compare
//   unit; its result is registered once the last range read has passed
//   the compare.
//   item_stall is high while a lookup scans, and while a result waits in
//   the output register with result_stall high; the result stays unchanged
//   until taken. One item is in work at a time.
//   Reset empties the table and the batch counter at once; the range
//   memory holds no reset value and needs no clearing pass.
module address_range_filter_table_core
    import arft_pkg::*;
#(
    parameter int MAX_RANGES  = MAX_RANGES_DEF,
    parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  arft_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output arft_result_t result
);

    localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W   = $clog2(MAX_RANGES + 1);
    localparam int BATCH_W = $clog2(BATCH_LIMIT + 1);

    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_RANGES);
    localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(BATCH_LIMIT);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               hit_acc_reg, hit_acc_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               out_valid_reg, out_valid_next;
    arft_result_t       out_reg, out_next;

    logic             accept;
    logic             wr_en;
    arft_range_t      wr_range;
    logic             rd_en;
    arft_range_t      rd_range;
    logic             match;
    logic             scan_more;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

    assign item_stall = (state_reg != S_IDLE) || (out_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    // Range ends are computed modulo 2^64.
    assign wr_range.range_lo = item.range_base + ADDR_W'(item.begin_offset);
    assign wr_range.range_hi = item.range_base + ADDR_W'(item.end_offset);

    assign scan_more = (idx_reg < count_reg);
    assign rd_en     = (state_reg == S_SCAN) && scan_more;

    // Shared compare unit: one stored range against the held address.
    assign match = (rd_range.range_lo <= addr_reg) && (addr_reg < rd_range.range_hi);

    arft_range_store #(
        .DEPTH (MAX_RANGES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (count_reg[IDX_W-1:0]),
        .wr_range (wr_range),
        .rd_en    (rd_en),
        .rd_idx   (idx_reg[IDX_W-1:0]),
        .rd_range (rd_range)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        batch_next     = batch_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        hit_acc_next   = hit_acc_reg;
        addr_next      = addr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        wr_en          = 1'b0;
        cnt_wide       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.hit    = 1'b0;
                    out_next.stored = 1'b0;
                    out_valid_next  = 1'b1;
                    priority if (item.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                        batch_next = '0;
                    end
                    else if (item.kind == KIND_ADD)
                    begin
                        if (batch_reg < BATCH_MAX)
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + 1'b1;
                                out_next.stored = 1'b1;
                            end
                            batch_next = batch_reg + 1'b1;
                        end
                        if (item.last_in_batch)
                        begin
                            batch_next = '0;
                        end
                    end
                    else if (item.kind == KIND_LOOKUP)
                    begin
                        if (count_reg == '0)
                        begin
                            out_next.hit = 1'b1;
                        end
                        else
                        begin
                            // Hold the result until the scan ends.
                            out_valid_next = 1'b0;
                            addr_next      = item.address;
                            idx_next       = '0;
                            hit_acc_next   = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        // Unused kind: report the count, change nothing.
                        count_next = count_reg;
                    end
                    cnt_wide             = {{COUNT_OUT_W{1'b0}}, count_next};
                    out_next.entry_count = cnt_wide[COUNT_OUT_W-1:0];
                end
            end
            S_SCAN:
            begin
                if (scan_more)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && match)
                begin
                    hit_acc_next = 1'b1;
                end
                if (!scan_more && !pend_reg)
                begin
                    cnt_wide             = {{COUNT_OUT_W{1'b0}}, count_next};
                    out_next.hit         = hit_acc_reg;
                    out_next.stored      = 1'b0;
                    out_next.entry_count = cnt_wide[COUNT_OUT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            batch_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            batch_reg     <= batch_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_acc_reg   <= hit_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
